### sv/ffsr_pkg.sv
// ----------------------------------------------------------------------------
// ffsr_pkg
// Shared constants, types and memory request structs of the first-fit slot
// reservation block.
// ----------------------------------------------------------------------------
package ffsr_pkg;

    localparam int MAX_RESOURCES = 8;
    localparam int SLOTS         = 1024;
    localparam int HOLDERS       = 256;

    localparam int RES_W    = $clog2(MAX_RESOURCES);
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int HOLDER_W = $clog2(HOLDERS);
    localparam int CFG_W    = 4;

    localparam int WORD_W  = 64;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int WIDX_W  = SLOT_W - BIT_W;
    localparam int SADDR_W = RES_W + WIDX_W;
    localparam int SWORDS  = MAX_RESOURCES * (SLOTS / WORD_W);

    localparam logic CMD_RESERVE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef logic [SADDR_W-1:0]  saddr_t;
    typedef logic [WORD_W-1:0]   sword_t;
    typedef logic [WIDX_W-1:0]   widx_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [RES_W-1:0]    res_t;
    typedef logic [HOLDER_W-1:0] holder_t;

    typedef struct packed {
        logic   rd_en;
        saddr_t rd_addr;
        logic   wr_en;
        saddr_t wr_addr;
        sword_t wr_data;
    } slot_req_t;

    typedef struct packed {
        res_t  res;
        slot_t first;
        slot_t last;
    } holder_ent_t;

    typedef struct packed {
        logic        rd_en;
        holder_t     rd_addr;
        logic        wr_en;
        logic        wr_valid;
        holder_t     wr_addr;
        holder_ent_t wr_data;
    } holder_req_t;

    typedef struct packed {
        logic        valid;
        holder_ent_t ent;
    } holder_rsp_t;

endpackage

### sv/ffsr_slot_mem.sv
// ----------------------------------------------------------------------------
// ffsr_slot_mem
// Busy-bit store: one 64-bit word per resource and word index, with a reset
// valid bit per word so that unwritten words read as all free.
// ----------------------------------------------------------------------------
module ffsr_slot_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  ffsr_pkg::slot_req_t req,
    output ffsr_pkg::sword_t    rd_data
);
    import ffsr_pkg::*;

    sword_t              mem [SWORDS];
    logic [SWORDS-1:0]   vld_reg;
    sword_t              q_reg;
    logic                q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                q_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = q_vld_reg ? q_reg : '0;

endmodule

### sv/ffsr_holder_mem.sv
// ----------------------------------------------------------------------------
// ffsr_holder_mem
// Holder table: resource and slot range per holder id, with a valid bit per
// entry that reset clears.
// ----------------------------------------------------------------------------
module ffsr_holder_mem (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffsr_pkg::holder_req_t req,
    output ffsr_pkg::holder_rsp_t rsp
);
    import ffsr_pkg::*;

    holder_ent_t          mem [HOLDERS];
    logic [HOLDERS-1:0]   vld_reg;
    holder_ent_t          q_reg;
    logic                 q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= req.wr_valid;
            end
            if (req.rd_en)
            begin
                q_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rsp.valid = q_vld_reg;
    assign rsp.ent   = q_reg;

endmodule

### sv/first_fit_slot_reservation_top.sv
// ----------------------------------------------------------------------------
// first_fit_slot_reservation_top
// First-fit reservation of slot ranges over several resources.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   reserve (cmd 0) of first_slot..last_slot for holder_id, or release
//   (cmd 1) of the range held by holder_id. Output channel
//   (out_valid/out_ready) returns exactly one result per command; a failure
//   returns all fields zero.
//   cfg_write_en/cfg_write_data set resources_in_use (reset 8); write only
//   while no command is in flight.
//   Commands are processed one at a time. After acceptance the block does
//   the holder lookup, then passes over the 64-slot words of the range,
//   one word read per cycle from the busy store, then loads the result
//   register. A reserve scans each searched resource in turn and then
//   marks the words of the range. A release clears the words of the range
//   it held; a rejected command goes from the holder lookup straight to the
//   result.
//   The result sits in an output register; the next command is accepted as
//   soon as the previous result has entered it, so a stalled receiver blocks
//   at most the second result.
//   Reset empties all resources and the holder table at once.
// ----------------------------------------------------------------------------
module first_fit_slot_reservation_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write_en,
    input  logic [3:0]              cfg_write_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    cmd,
    input  ffsr_pkg::holder_t       holder_id,
    input  ffsr_pkg::slot_t         first_slot,
    input  ffsr_pkg::slot_t         last_slot,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    ok,
    output ffsr_pkg::res_t          resource,
    output ffsr_pkg::slot_t         range_first,
    output ffsr_pkg::slot_t         range_last,
    output ffsr_pkg::holder_t       holder_out
);
    import ffsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HREAD,
        S_SCAN,
        S_RMW,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic                 cmd_reg, cmd_next;
    holder_t              id_reg, id_next;
    slot_t                first_reg, first_next;
    slot_t                last_reg, last_next;
    res_t                 res_reg, res_next;
    widx_t                iss_w_reg, iss_w_next;
    widx_t                chk_w_reg, chk_w_next;
    logic                 pend_reg, pend_next;
    logic                 set_reg, set_next;
    logic                 rok_reg, rok_next;
    logic [CFG_W-1:0]     riu_reg, riu_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 ok_reg, ok_next;
    res_t                 resource_reg, resource_next;
    slot_t                rf_reg, rf_next;
    slot_t                rl_reg, rl_next;
    holder_t              ho_reg, ho_next;

    slot_req_t            sreq;
    sword_t               srd;
    holder_req_t          hreq;
    holder_rsp_t          hrsp;

    widx_t                first_w;
    widx_t                last_w;
    logic [CFG_W-1:0]     count;
    res_t                 res_inc;
    logic [CFG_W-1:0]     res_inc_cnt;
    sword_t               mask;
    logic                 conflict;
    logic                 out_free;
    logic                 reject;

    function automatic sword_t range_mask(widx_t w, slot_t lo_slot, slot_t hi_slot);
        logic [BIT_W-1:0] lo;
        logic [BIT_W-1:0] hi;
        sword_t           ones;
        ones = '1;
        lo   = (w == lo_slot[SLOT_W-1:BIT_W]) ? lo_slot[BIT_W-1:0] : '0;
        hi   = (w == hi_slot[SLOT_W-1:BIT_W]) ? hi_slot[BIT_W-1:0] : '1;
        return (ones << lo) & (ones >> (BIT_W'(WORD_W - 1) - hi));
    endfunction

    ffsr_slot_mem u_slot_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sreq),
        .rd_data (srd)
    );

    ffsr_holder_mem u_holder_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .rsp   (hrsp)
    );

    assign first_w     = first_reg[SLOT_W-1:BIT_W];
    assign last_w      = last_reg[SLOT_W-1:BIT_W];
    assign count       = (riu_reg > CFG_W'(MAX_RESOURCES)) ? CFG_W'(MAX_RESOURCES) : riu_reg;
    assign res_inc     = res_reg + 1'b1;
    assign res_inc_cnt = CFG_W'(res_reg) + 1'b1;
    assign mask        = range_mask(chk_w_reg, first_reg, last_reg);
    assign conflict    = pend_reg && ((srd & mask) != '0);
    assign out_free    = !out_valid_reg || out_ready;
    assign reject      = hrsp.valid || (first_reg > last_reg) || (first_reg == '0)
                         || (count == '0);

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign resource    = resource_reg;
    assign range_first = rf_reg;
    assign range_last  = rl_reg;
    assign holder_out  = ho_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        iss_w_next     = iss_w_reg;
        chk_w_next     = chk_w_reg;
        pend_next      = pend_reg;
        set_next       = set_reg;
        rok_next       = rok_reg;
        riu_next       = cfg_write_en ? cfg_write_data : riu_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ok_next        = ok_reg;
        resource_next  = resource_reg;
        rf_next        = rf_reg;
        rl_next        = rl_reg;
        ho_next        = ho_reg;
        sreq           = '0;
        hreq           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = cmd;
                    id_next      = holder_id;
                    first_next   = first_slot;
                    last_next    = last_slot;
                    hreq.rd_en   = 1'b1;
                    hreq.rd_addr = holder_id;
                    state_next   = S_HREAD;
                end
            end

            S_HREAD:
            begin
                pend_next = 1'b0;
                if (cmd_reg == CMD_RELEASE)
                begin
                    if (!hrsp.valid)
                    begin
                        rok_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        res_next      = hrsp.ent.res;
                        first_next    = hrsp.ent.first;
                        last_next     = hrsp.ent.last;
                        iss_w_next    = hrsp.ent.first[SLOT_W-1:BIT_W];
                        set_next      = 1'b0;
                        hreq.wr_en    = 1'b1;
                        hreq.wr_valid = 1'b0;
                        hreq.wr_addr  = id_reg;
                        hreq.wr_data  = hrsp.ent;
                        state_next    = S_RMW;
                    end
                end
                else if (reject)
                begin
                    rok_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    res_next   = '0;
                    iss_w_next = first_w;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (conflict)
                begin
                    if (res_inc_cnt >= count)
                    begin
                        pend_next  = 1'b0;
                        rok_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        res_next     = res_inc;
                        sreq.rd_en   = 1'b1;
                        sreq.rd_addr = {res_inc, first_w};
                        chk_w_next   = first_w;
                        iss_w_next   = first_w + 1'b1;
                        pend_next    = 1'b1;
                    end
                end
                else if (pend_reg && (chk_w_reg == last_w))
                begin
                    hreq.wr_en         = 1'b1;
                    hreq.wr_valid      = 1'b1;
                    hreq.wr_addr       = id_reg;
                    hreq.wr_data.res   = res_reg;
                    hreq.wr_data.first = first_reg;
                    hreq.wr_data.last  = last_reg;
                    set_next           = 1'b1;
                    iss_w_next         = first_w;
                    pend_next          = 1'b0;
                    state_next         = S_RMW;
                end
                else if (iss_w_reg <= last_w)
                begin
                    sreq.rd_en   = 1'b1;
                    sreq.rd_addr = {res_reg, iss_w_reg};
                    chk_w_next   = iss_w_reg;
                    iss_w_next   = iss_w_reg + 1'b1;
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_RMW:
            begin
                if (pend_reg)
                begin
                    sreq.wr_en   = 1'b1;
                    sreq.wr_addr = {res_reg, chk_w_reg};
                    sreq.wr_data = set_reg ? (srd | mask) : (srd & ~mask);
                end
                if (pend_reg && (chk_w_reg == last_w))
                begin
                    pend_next  = 1'b0;
                    rok_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (iss_w_reg <= last_w)
                begin
                    sreq.rd_en   = 1'b1;
                    sreq.rd_addr = {res_reg, iss_w_reg};
                    chk_w_next   = iss_w_reg;
                    iss_w_next   = iss_w_reg + 1'b1;
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = rok_reg;
                    resource_next  = rok_reg ? res_reg : '0;
                    rf_next        = rok_reg ? first_reg : '0;
                    rl_next        = rok_reg ? last_reg : '0;
                    ho_next        = (rok_reg && (cmd_reg == CMD_RESERVE)) ? id_reg : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= 1'b0;
            id_reg        <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            res_reg       <= '0;
            iss_w_reg     <= '0;
            chk_w_reg     <= '0;
            pend_reg      <= 1'b0;
            set_reg       <= 1'b0;
            rok_reg       <= 1'b0;
            riu_reg       <= CFG_W'(MAX_RESOURCES);
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            resource_reg  <= '0;
            rf_reg        <= '0;
            rl_reg        <= '0;
            ho_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            id_reg        <= id_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            res_reg       <= res_next;
            iss_w_reg     <= iss_w_next;
            chk_w_reg     <= chk_w_next;
            pend_reg      <= pend_next;
            set_reg       <= set_next;
            rok_reg       <= rok_next;
            riu_reg       <= riu_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            resource_reg  <= resource_next;
            rf_reg        <= rf_next;
            rl_reg        <= rl_next;
            ho_reg        <= ho_next;
        end
    end

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (sreq.wr_en && sreq.rd_en) |-> (sreq.wr_addr != sreq.rd_addr))
        else $error("busy store read and write hit the same word");

    a_scan_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CFG_W'(res_reg) < count))
        else $error("scan resource beyond searched count");

    a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && ((state_reg == S_SCAN) || (state_reg == S_RMW)))
        |-> ((chk_w_reg >= first_w) && (chk_w_reg <= last_w)))
        else $error("checked word outside the range");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_HREAD))
        else $error("accepted transaction did not start holder lookup");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> ((resource == '0) && (range_first == '0)
        && (range_last == '0) && (holder_out == '0)))
        else $error("failed result carries nonzero fields");

endmodule

### tb/sv/tb_first_fit_slot_reservation_top.sv
// ----------------------------------------------------------------------------
// tb_first_fit_slot_reservation_top
// Self-checking bench for the first-fit slot reservation block. A clocked
// driver feeds reserve and release commands from a queue; a clocked monitor
// compares every result with a booking model that tracks slot occupancy per
// resource and the holder table. Both channels idle at random, and the
// searched resource count is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_first_fit_slot_reservation_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ffsr_pkg::*;

    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   REPORT_MAX  = 10;

    typedef struct packed {
        logic    cmd;
        holder_t id;
        slot_t   first;
        slot_t   last;
        logic    hold;
    } command_t;

    typedef struct packed {
        logic    ok;
        res_t    res;
        slot_t   first;
        slot_t   last;
        holder_t holder;
    } reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write_en = 1'b0;
    logic [3:0] cfg_write_data = 4'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       cmd = 1'b0;
    holder_t    holder_id = '0;
    slot_t      first_slot = '0;
    slot_t      last_slot = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       ok;
    res_t       resource;
    slot_t      range_first;
    slot_t      range_last;
    holder_t    holder_out;

    first_fit_slot_reservation_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .holder_id     (holder_id),
        .first_slot    (first_slot),
        .last_slot     (last_slot),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .resource      (resource),
        .range_first   (range_first),
        .range_last    (range_last),
        .holder_out    (holder_out)
    );

    always #2 clk = ~clk;

    // booking model state
    bit    slot_taken [MAX_RESOURCES][SLOTS];
    bit    holder_live [HOLDERS];
    res_t  holder_res [HOLDERS];
    slot_t holder_first [HOLDERS];
    slot_t holder_last [HOLDERS];
    int    searched_count = 8;

    bit       guess_held [HOLDERS];
    command_t command_q [$];
    reply_t   pending_replies [$];
    command_t on_wire;
    reply_t   want;
    reply_t   got;

    bit burst = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int mismatches = 0;
    int cycles = 0;
    int accepted = 0;
    int granted = 0;
    int freed = 0;
    int refused = 0;
    int no_room = 0;
    int settings = 0;

    function automatic reply_t book_slots(command_t c);
        reply_t r;
        int     n;
        int     k;
        int     s;
        bit     clear;
        r = '0;
        if (c.cmd == CMD_RELEASE)
        begin
            if (!holder_live[c.id])
            begin
                refused++;
                return r;
            end
            for (s = holder_first[c.id]; s <= holder_last[c.id]; s++)
                slot_taken[holder_res[c.id]][s] = 1'b0;
            holder_live[c.id] = 1'b0;
            r.ok = 1'b1;
            r.res = holder_res[c.id];
            r.first = holder_first[c.id];
            r.last = holder_last[c.id];
            freed++;
            return r;
        end
        if (holder_live[c.id] || c.first > c.last || c.first == 0)
        begin
            refused++;
            return r;
        end
        n = (searched_count > MAX_RESOURCES) ? MAX_RESOURCES : searched_count;
        for (k = 0; k < n; k++)
        begin
            clear = 1'b1;
            for (s = c.first; s <= c.last; s++)
                if (slot_taken[k][s])
                    clear = 1'b0;
            if (clear)
            begin
                for (s = c.first; s <= c.last; s++)
                    slot_taken[k][s] = 1'b1;
                holder_live[c.id] = 1'b1;
                holder_res[c.id] = res_t'(k);
                holder_first[c.id] = c.first;
                holder_last[c.id] = c.last;
                r.ok = 1'b1;
                r.res = res_t'(k);
                r.first = c.first;
                r.last = c.last;
                r.holder = c.id;
                granted++;
                return r;
            end
        end
        refused++;
        no_room++;
        return r;
    endfunction

    function automatic int idle_length();
        return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] %s", $realtime, what);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_replies = {pending_replies, book_slots(on_wire)};
                accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (command_q.size() > 0 &&
                         (!command_q[0].hold || pending_replies.size() == 0))
                begin
                    on_wire = command_q.pop_front();
                    cmd <= on_wire.cmd;
                    holder_id <= on_wire.id;
                    first_slot <= on_wire.first;
                    last_slot <= on_wire.last;
                    in_valid <= 1'b1;
                    gap_left <= (burst || $urandom_range(0, 1) == 0) ? 0 : idle_length();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.ok = ok;
                got.res = resource;
                got.first = range_first;
                got.last = range_last;
                got.holder = holder_out;
                if (pending_replies.size() == 0)
                    note_mismatch($sformatf(
                        "result with no command pending: ok=%0d res=%0d %0d..%0d holder=%0d",
                        got.ok, got.res, got.first, got.last, got.holder));
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.ok !== want.ok || got.res !== want.res || got.first !== want.first ||
                        got.last !== want.last || got.holder !== want.holder)
                        note_mismatch($sformatf(
                            {"mismatch: expected ok=%0d res=%0d %0d..%0d holder=%0d, ",
                             "got ok=%0d res=%0d %0d..%0d holder=%0d"},
                            want.ok, want.res, want.first, want.last, want.holder,
                            got.ok, got.res, got.first, got.last, got.holder));
                end
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!burst && $urandom_range(0, 99) < 20)
            begin
                out_ready <= 1'b0;
                stall_left <= idle_length() - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_replies.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_idle(int settle);
        while (command_q.size() > 0 || in_valid || pending_replies.size() > 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_resource_count(logic [3:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        searched_count = int'(value);
        settings++;
    endtask

    task automatic queue_command(logic c, int id, int f, int l);
        command_t item;
        item = '0;
        item.cmd = c;
        item.id = holder_t'(id);
        item.first = slot_t'(f);
        item.last = slot_t'(l);
        command_q = {command_q, item};
    endtask

    task automatic queue_phase(int count);
        command_t c;
        int       wlo;
        int       wsize;
        int       len;
        int       p;
        int       i;
        int       k;
        int       tries;
        int       held_ids [$];
        if ($urandom_range(0, 2) == 0)
        begin
            wlo = 1 + $urandom_range(0, 200);
            wsize = SLOTS - wlo;
        end
        else
        begin
            wlo = 1 + $urandom_range(0, 960);
            wsize = $urandom_range(16, 64);
            if (wlo + wsize > SLOTS)
                wsize = SLOTS - wlo;
        end
        for (k = 0; k < HOLDERS; k++)
            guess_held[k] = holder_live[k];
        for (i = 0; i < count; i++)
        begin
            c = '0;
            c.hold = ($urandom_range(0, 49) == 0);
            held_ids.delete();
            for (k = 0; k < HOLDERS; k++)
                if (guess_held[k])
                    held_ids = {held_ids, k};
            p = $urandom_range(0, 99);
            if (p < 55)
            begin
                c.cmd = CMD_RESERVE;
                c.id = holder_t'($urandom_range(0, HOLDERS - 1));
                for (tries = 0; tries < 8 && guess_held[c.id]; tries++)
                    c.id = holder_t'($urandom_range(0, HOLDERS - 1));
                p = $urandom_range(0, 99);
                len = (p < 70) ? $urandom_range(1, 8) :
                      (p < 95) ? $urandom_range(9, 64) : $urandom_range(65, wsize);
                if (len > wsize)
                    len = wsize;
                c.first = slot_t'(wlo + $urandom_range(0, wsize - len));
                c.last = slot_t'(c.first + len - 1);
                guess_held[c.id] = 1'b1;
            end
            else if (p < 85 && held_ids.size() > 0)
            begin
                c.cmd = CMD_RELEASE;
                c.id = holder_t'(held_ids[$urandom_range(0, held_ids.size() - 1)]);
                guess_held[c.id] = 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        c.cmd = CMD_RESERVE;
                        c.id = holder_t'($urandom_range(0, HOLDERS - 1));
                        c.first = slot_t'($urandom_range(1, SLOTS - 1));
                        c.last = slot_t'($urandom_range(0, c.first - 1));
                    end
                    1:
                    begin
                        c.cmd = CMD_RESERVE;
                        c.id = holder_t'($urandom_range(0, HOLDERS - 1));
                        c.first = '0;
                        c.last = slot_t'($urandom_range(0, SLOTS - 1));
                    end
                    2:
                    begin
                        c.cmd = CMD_RESERVE;
                        c.id = holder_t'((held_ids.size() > 0) ?
                               held_ids[$urandom_range(0, held_ids.size() - 1)] :
                               $urandom_range(0, HOLDERS - 1));
                        c.first = slot_t'($urandom_range(1, SLOTS - 1));
                        c.last = slot_t'($urandom_range(c.first, SLOTS - 1));
                    end
                    3:
                    begin
                        c.cmd = CMD_RELEASE;
                        c.id = holder_t'($urandom_range(0, HOLDERS - 1));
                    end
                    default:
                    begin
                        c.cmd = 1'($urandom_range(0, 1));
                        c.id = holder_t'($urandom_range(0, HOLDERS - 1));
                        c.first = slot_t'($urandom_range(0, SLOTS - 1));
                        c.last = slot_t'($urandom_range(0, SLOTS - 1));
                    end
                endcase
            end
            command_q = {command_q, c};
        end
    endtask

    int setting_plan [] = '{1, 0, 15, 3, 8, 2, 5, 7, 8, 0};
    int phase;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_resource_count(4'd8);

        queue_command(CMD_RESERVE, 0, 1, 1);
        queue_command(CMD_RESERVE, 255, 1, 1023);
        queue_command(CMD_RESERVE, 0, 2, 3);
        queue_command(CMD_RESERVE, 1, 5, 4);
        queue_command(CMD_RESERVE, 1, 0, 3);
        queue_command(CMD_RESERVE, 1, 0, 0);
        queue_command(CMD_RESERVE, 2, 1023, 1023);
        queue_command(CMD_RELEASE, 3, 0, 0);
        queue_command(CMD_RELEASE, 255, 0, 0);
        queue_command(CMD_RELEASE, 255, 0, 0);
        for (int i = 0; i < 8; i++)
            queue_command(CMD_RESERVE, 10 + i, 100, 100);
        queue_command(CMD_RESERVE, 18, 100, 100);
        queue_command(CMD_RELEASE, 0, 1023, 1023);
        queue_command(CMD_RELEASE, 2, 0, 0);
        queue_command(CMD_RESERVE, 1, 1, 1023);
        queue_command(CMD_RESERVE, 1, 101, 1023);

        for (phase = 0; phase < setting_plan.size(); phase++)
        begin
            wait_idle(4);
            burst = (phase % 3 == 2);
            write_resource_count(4'(setting_plan[phase] == 0 && phase > 1 ?
                                     $urandom_range(0, 15) : setting_plan[phase]));
            queue_phase(88);
        end

        wait_idle(40);
        $display("%0d commands: %0d grants, %0d releases, %0d refusals (%0d with no free resource)",
                 accepted, granted, freed, refused, no_room);
        $display("%0d resource-count settings applied, %0d mismatches", settings, mismatches);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
